/* src/mlaes_pkg.sv */
package mlaes_pkg;

   localparam int MAX_LEVELS_DEFAULT  = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam logic [3:0] LEVELS_RESET = 4'd4;

   localparam logic REQ_ADD = 1'b0;
   localparam logic REQ_GET = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   // result of one request, without the dequeued id (that comes from the ram)
   typedef struct packed {
      status_type        status;
      logic              pop;
      logic [2:0]        level;
      logic              to_expired;
      logic signed [3:0] new_dyn_prio;
   } result_type;

endpackage

/* src/mlaes_ram.sv */
module mlaes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mlaes_ctrl.sv */
module mlaes_ctrl #(
   parameter int MAX_LEVELS  = mlaes_pkg::MAX_LEVELS_DEFAULT,
   parameter int QUEUE_DEPTH = mlaes_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1,
   localparam int FW = LW + 1,
   localparam int PW = $clog2(QUEUE_DEPTH),
   localparam int AW = FW + PW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   req_type,
   input  logic [7:0]             proc_id,
   input  logic signed [3:0]      dyn_prio,
   input  logic [3:0]             static_prio,
   input  logic [3:0]             levels_in_use,
   output mlaes_pkg::result_type  result,
   output logic                   wr_en,
   output logic [AW-1:0]          wr_addr,
   output logic [7:0]             wr_data,
   output logic                   rd_en,
   output logic [AW-1:0]          rd_addr
);

   localparam int NF = 2 ** FW;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [PW-1:0] head_ff [NF];
   logic [PW-1:0] head_in [NF];
   logic [PW-1:0] tail_ff [NF];
   logic [PW-1:0] tail_in [NF];
   logic [CW-1:0] fill_ff [NF];
   logic [CW-1:0] fill_in [NF];
   logic          bank_ff;
   logic          bank_in;

   logic [4:0]        lev_eff;
   logic              expired;
   logic signed [4:0] lvl_s;
   logic              in_range;
   logic [FW-1:0]     push_fifo;
   logic              full;
   logic              do_push;
   logic [MAX_LEVELS-1:0] act_ne;
   logic [MAX_LEVELS-1:0] exp_ne;
   logic [MAX_LEVELS-1:0] sel_ne;
   logic              any_act;
   logic              found;
   logic [LW-1:0]     top;
   logic              pop_bank;
   logic [FW-1:0]     pop_fifo;
   logic              do_pop;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // clamp the levels register to 1..MAX_LEVELS
   always_comb begin
      if (levels_in_use == 4'd0) begin
         lev_eff = 5'd1;
      end else if ({1'b0, levels_in_use} > 5'(MAX_LEVELS)) begin
         lev_eff = 5'(MAX_LEVELS);
      end else begin
         lev_eff = {1'b0, levels_in_use};
      end
   end

   // add path
   always_comb begin
      expired   = dyn_prio[3];
      lvl_s     = expired ? ($signed({1'b0, static_prio}) - 5'sd1) : {dyn_prio[3], dyn_prio};
      in_range  = !lvl_s[4] && ({1'b0, lvl_s[3:0]} < lev_eff);
      push_fifo = {bank_ff ^ expired, lvl_s[LW-1:0]};
      full      = (fill_ff[push_fifo] == CW'(QUEUE_DEPTH));
      do_push   = (req_type == mlaes_pkg::REQ_ADD) && in_range && !full;
   end

   // get path: highest non-empty level, in the expired bank if active is empty
   always_comb begin
      for (int l = 0; l < MAX_LEVELS; l++) begin
         act_ne[l] = (5'(l) < lev_eff) && (fill_ff[{bank_ff, LW'(l)}] != '0);
         exp_ne[l] = (5'(l) < lev_eff) && (fill_ff[{~bank_ff, LW'(l)}] != '0);
      end
      any_act  = |act_ne;
      sel_ne   = any_act ? act_ne : exp_ne;
      pop_bank = any_act ? bank_ff : ~bank_ff;
      found    = |sel_ne;
      top      = '0;
      for (int l = 0; l < MAX_LEVELS; l++) begin
         if (sel_ne[l]) begin
            top = LW'(l);
         end
      end
      pop_fifo = {pop_bank, top};
      do_pop   = (req_type == mlaes_pkg::REQ_GET) && found;
   end

   always_comb begin
      result = '0;
      if (req_type == mlaes_pkg::REQ_ADD) begin
         if (!in_range) begin
            result.status       = mlaes_pkg::STATUS_RANGE;
            result.new_dyn_prio = dyn_prio;
         end else begin
            result.status       = full ? mlaes_pkg::STATUS_FULL : mlaes_pkg::STATUS_OK;
            result.level        = lvl_s[2:0];
            result.to_expired   = expired;
            result.new_dyn_prio = lvl_s[3:0];
         end
      end else if (found) begin
         result.status = mlaes_pkg::STATUS_OK;
         result.pop    = 1'b1;
         result.level  = 3'(top);
      end else begin
         result.status = mlaes_pkg::STATUS_EMPTY;
      end
   end

   assign wr_en   = advance && do_push;
   assign wr_addr = {push_fifo, tail_ff[push_fifo]};
   assign wr_data = proc_id;
   assign rd_en   = advance && do_pop;
   assign rd_addr = {pop_fifo, head_ff[pop_fifo]};

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      bank_in = bank_ff;
      if (advance) begin
         if (do_push) begin
            tail_in[push_fifo] = ptr_inc(tail_ff[push_fifo]);
            fill_in[push_fifo] = fill_ff[push_fifo] + 1'b1;
         end
         if (req_type == mlaes_pkg::REQ_GET && !any_act) begin
            bank_in = ~bank_ff;
         end
         if (do_pop) begin
            head_in[pop_fifo] = ptr_inc(head_ff[pop_fifo]);
            fill_in[pop_fifo] = fill_ff[pop_fifo] - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < NF; f++) begin
            head_ff[f] <= '0;
            tail_ff[f] <= '0;
            fill_ff[f] <= '0;
         end
         bank_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
         bank_ff <= bank_in;
      end
   end

endmodule

/* src/multilevel_active_expired_scheduler.sv */
// Ready-queue scheduler with an active and an expired bank of per-level
// process-id FIFOs. One request (add or get) is accepted every clock cycle
// while the response side is not stalled; each request gives exactly one
// response: it passes through the request register, where the queue
// pointers are updated and the FIFO storage ram is written or read, and then
// the response register, with the ram's registered read data supplying the
// dequeued id. A stalled response holds the pipeline, and one more request
// is still taken into the request register while the response register waits.
// csr_wdata sets the number of levels in use
// (clamped to 1..MAX_LEVELS, reset 4); write it only while no request is in
// flight. Storage is a single ram of 2 * 2^max(1, ceil(log2(MAX_LEVELS))) FIFOs of
// QUEUE_DEPTH slots each (rounded up to a power of two); it needs no clearing.
module multilevel_active_expired_scheduler #(
   parameter int MAX_LEVELS  = mlaes_pkg::MAX_LEVELS_DEFAULT,
   parameter int QUEUE_DEPTH = mlaes_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // proc_id[7:0], dyn_prio[11:8], static_prio[15:12]
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // proc_out[7:0], level_out[10:8], to_expired[11],
                                    // new_dyn_prio[15:12]
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_wdata    // levels_in_use
);

   localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int FW = LW + 1;
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int AW = FW + PW;
   localparam int RAM_DEPTH = 2 ** AW;

   logic [3:0]            levels_val_ff;
   logic                  s1_vld_ff;
   logic                  s1_type_ff;
   logic [7:0]            s1_id_ff;
   logic signed [3:0]     s1_dyn_ff;
   logic [3:0]            s1_stat_ff;
   logic                  rsp_vld_ff;
   mlaes_pkg::result_type res_ff;
   mlaes_pkg::result_type res_in;
   logic                  advance;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [7:0]            wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [7:0]            rd_data;
   logic [7:0]            proc_out;

   assign csr_ready  = 1'b1;
   assign advance    = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_val_ff <= mlaes_pkg::LEVELS_RESET;
      end else begin
         if (csr_valid) begin
            levels_val_ff <= csr_wdata;
         end
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_tready) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_type_ff <= req_tuser;
         s1_id_ff   <= req_tdata[7:0];
         s1_dyn_ff  <= req_tdata[11:8];
         s1_stat_ff <= req_tdata[15:12];
      end
   end

   mlaes_ctrl #(
      .MAX_LEVELS  (MAX_LEVELS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .req_type      (s1_type_ff),
      .proc_id       (s1_id_ff),
      .dyn_prio      (s1_dyn_ff),
      .static_prio   (s1_stat_ff),
      .levels_in_use (levels_val_ff),
      .result        (res_in),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr)
   );

   mlaes_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // response register; the ram read data is captured on the same edge
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign proc_out   = res_ff.pop ? rd_data : 8'd0;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = res_ff.status;
   assign rsp_tdata  = {res_ff.new_dyn_prio, res_ff.to_expired, res_ff.level, proc_out};

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

   localparam int MAXL         = mlaes_pkg::MAX_LEVELS_DEFAULT;
   localparam int DEPTH        = mlaes_pkg::QUEUE_DEPTH_DEFAULT;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 60;
   localparam int SETTLE       = 6;
   localparam int EXP_SLOTS    = 1024;

   typedef struct {
      mlaes_pkg::status_type status;
      logic [7:0]        proc_id;
      logic [2:0]        level;
      logic              to_expired;
      logic signed [3:0] dyn_prio;
   } sched_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = mlaes_pkg::REQ_ADD;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_wdata = '0;

   // scheduler state as the checker sees it
   logic [7:0]  id_slots [2*MAXL][DEPTH];
   int          slot_head [2*MAXL];
   int          slot_tail [2*MAXL];
   int          slot_fill [2*MAXL];
   int          active_bank = 0;
   logic [3:0]  levels_reg = mlaes_pkg::LEVELS_RESET;

   // expected responses in request order
   sched_rsp_type exp_fifo [EXP_SLOTS];
   int          exp_wr = 0;
   int          exp_rd = 0;
   int          sent_total = 0;
   int          fail_count = 0;
   int          quiet_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_pending = 0;
   int          hold_left = 0;

   multilevel_active_expired_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int levels_active();
      if (levels_reg == 0) return 1;
      if (levels_reg > MAXL) return MAXL;
      return int'(levels_reg);
   endfunction

   function automatic int highest_ready(int bank);
      for (int i = levels_active() - 1; i >= 0; i--) begin
         if (slot_fill[bank*MAXL + i] != 0) return i;
      end
      return -1;
   endfunction

   function automatic sched_rsp_type predict_schedule(logic rtype, logic [7:0] pid,
                                                      logic signed [3:0] dp, logic [3:0] sp);
      sched_rsp_type r;
      int lvl;
      int q;
      int top;
      logic expired;
      r.status = mlaes_pkg::STATUS_OK;
      r.proc_id = '0;
      r.level = '0;
      r.to_expired = 1'b0;
      r.dyn_prio = '0;
      if (rtype == mlaes_pkg::REQ_ADD) begin
         expired = (dp < 0);
         if (expired) lvl = int'(sp) - 1;
         else lvl = int'(dp);
         if (lvl < 0 || lvl >= levels_active()) begin
            r.status = mlaes_pkg::STATUS_RANGE;
            r.dyn_prio = dp;
            return r;
         end
         r.level = lvl[2:0];
         r.to_expired = expired;
         r.dyn_prio = lvl[3:0];
         q = (expired ? 1 - active_bank : active_bank) * MAXL + lvl;
         if (slot_fill[q] >= DEPTH) begin
            r.status = mlaes_pkg::STATUS_FULL;
            return r;
         end
         id_slots[q][slot_tail[q]] = pid;
         slot_tail[q] = (slot_tail[q] + 1) % DEPTH;
         slot_fill[q]++;
         return r;
      end
      top = highest_ready(active_bank);
      // active side empty: banks trade places, even when both are empty
      if (top < 0) begin
         active_bank = 1 - active_bank;
         top = highest_ready(active_bank);
      end
      if (top < 0) begin
         r.status = mlaes_pkg::STATUS_EMPTY;
         return r;
      end
      q = active_bank*MAXL + top;
      r.proc_id = id_slots[q][slot_head[q]];
      r.level = top[2:0];
      slot_head[q] = (slot_head[q] + 1) % DEPTH;
      slot_fill[q]--;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (fail_count < 40) $display("mismatch: %s got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin : monitor
      sched_rsp_type want;
      if (!reset) begin
         quiet_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            quiet_cycles = 0;
            if (exp_wr == exp_rd) begin
               report_mismatch("response with no request outstanding", rsp_tdata, 0);
            end else begin
               want = exp_fifo[exp_rd % EXP_SLOTS];
               exp_rd++;
               if (rsp_tuser !== want.status)
                  report_mismatch("status", rsp_tuser, int'(want.status));
               if (rsp_tdata[7:0] !== want.proc_id)
                  report_mismatch("proc_out", rsp_tdata[7:0], want.proc_id);
               if (rsp_tdata[10:8] !== want.level)
                  report_mismatch("level_out", rsp_tdata[10:8], want.level);
               if (rsp_tdata[11] !== want.to_expired)
                  report_mismatch("to_expired", rsp_tdata[11], want.to_expired);
               if (rsp_tdata[15:12] !== want.dyn_prio)
                  report_mismatch("new_dyn_prio", $signed(rsp_tdata[15:12]), want.dyn_prio);
            end
         end
         if (req_tvalid && req_tready) begin
            quiet_cycles = 0;
            exp_fifo[exp_wr % EXP_SLOTS] = predict_schedule(req_tuser, req_tdata[7:0],
                                                            req_tdata[11:8], req_tdata[15:12]);
            exp_wr++;
         end
         if (csr_valid && csr_ready) begin
            quiet_cycles = 0;
            levels_reg = csr_wdata;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_pending) begin
         hold_left = HOLD_CYCLES;
         hold_pending = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   initial begin : watchdog
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // valid stays up between back-to-back requests; it drops only while idling
   task automatic send_request(input logic rtype, input logic [7:0] pid,
                               input logic [3:0] dp, input logic [3:0] sp);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= rtype;
      req_tdata <= {sp, dp, pid};
      do @(posedge clock); while (!req_tready);
      sent_total++;
   endtask

   task automatic send_random(input int add_pct);
      logic [7:0] pid;
      logic [3:0] dp;
      logic [3:0] sp;
      int lv;
      lv = levels_active();
      pid = 8'($urandom_range(255, 0));
      dp = 4'($urandom_range(15, 0));
      sp = 4'($urandom_range(15, 0));
      if ($urandom_range(99, 0) < add_pct) begin
         // mostly priorities that land in a level in use
         if ($urandom_range(9, 0) < 8) begin
            if ($urandom_range(1, 0) == 1) dp = 4'($urandom_range(lv - 1, 0));
            else begin
               dp = 4'($urandom_range(15, 8));
               sp = 4'($urandom_range(lv, 1));
            end
         end
         send_request(mlaes_pkg::REQ_ADD, pid, dp, sp);
      end else begin
         send_request(mlaes_pkg::REQ_GET, pid, dp, sp);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (exp_rd != sent_total) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_levels(input logic [3:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [3:0] levels, input int send_idle, input int recv_stall,
                            input int count, input int add_pct);
      set_levels(levels);
      send_idle_pct = send_idle;
      recv_stall_pct = recv_stall;
      repeat (count) send_random(add_pct);
   endtask

   // reset value of four levels in use
   task automatic test_basic_requests();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_request(mlaes_pkg::REQ_GET, 8'h00, 4'h0, 4'h0);     // nothing ready
      send_request(mlaes_pkg::REQ_ADD, 8'h00, 4'h0, 4'h0);
      send_request(mlaes_pkg::REQ_ADD, 8'hFF, 4'h3, 4'h0);
      send_request(mlaes_pkg::REQ_ADD, 8'h11, 4'h4, 4'h1);     // one past the top level
      // expired, static 0 maps below level 0
      send_request(mlaes_pkg::REQ_ADD, 8'h22, 4'hF, 4'h0);
      // most negative priority, expired bank
      send_request(mlaes_pkg::REQ_ADD, 8'h5A, 4'h8, 4'h4);
      send_request(mlaes_pkg::REQ_ADD, 8'h33, 4'h7, 4'hF);
      send_request(mlaes_pkg::REQ_GET, 8'hFF, 4'hF, 4'hF);
      send_request(mlaes_pkg::REQ_GET, 8'h00, 4'h0, 4'h0);
      send_request(mlaes_pkg::REQ_GET, 8'h00, 4'h0, 4'h0);     // active empty, banks swap
   endtask

   task automatic test_queue_full();
      set_levels(4'd1);
      for (int i = 0; i < DEPTH; i++) send_request(mlaes_pkg::REQ_ADD, 8'(i * 17), 4'h0, 4'h0);
      send_request(mlaes_pkg::REQ_ADD, 8'hC3, 4'h0, 4'h0);     // dropped
   endtask

   task automatic test_random_traffic();
      run_phase(4'd8,  0,  0,  100, 60);
      run_phase(4'd1,  71, 0,  80,  75);
      run_phase(4'd0,  0,  71, 60,  50);            // clamps to one level
      run_phase(4'd15, 16, 16, 100, 55);            // clamps to the maximum
      run_phase(4'd3,  0,  0,  80,  35);
      run_phase(4'd5,  71, 0,  60,  50);
      run_phase(4'd4,  0,  0,  40,  50);
   endtask

   // receiver holds off while requests keep coming, so the pipe backs up
   task automatic test_backpressure();
      set_levels(4'd8);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_pending = 1;
      repeat (30) send_random(50);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_basic_requests();
      test_queue_full();
      test_random_traffic();
      test_backpressure();
      wait_drained();
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
